FILE: hw/rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTF8SD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8 decoder: assertion failed");

// Next-cycle implication, disabled during reset.
`define UTF8SD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8 decoder: assertion failed");

`endif

FILE: hw/rtl/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder.
package utf8sd_pkg;

	localparam int CpWidth  = 22;
	localparam int AccWidth = 21;
	localparam int FifoDepth = 4;
	localparam int PtrWidth  = $clog2(FifoDepth);
	localparam int CntWidth  = $clog2(FifoDepth + 1);

	// Malformed sequences are reported as -1.
	localparam logic signed [CpWidth-1:0] CP_ERROR = '1;

	// Byte classes of the lead and continuation decoding.
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_VAL   = 8'h80;

	typedef struct packed {
		logic signed [CpWidth-1:0] code_point;
		logic                      is_last;
	} result_t;

endpackage

FILE: hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte register, decode logic and result queue.
// Depends on utf8sd_pkg and utf8_stream_decoder_assert.svh.
//
//  channel | direction | handshake          | words
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | in_byte
//  out     | output    | out_valid/out_stall| code_point, is_last
//
// One byte is taken every cycle while the result queue has room for two words.
// A byte passes through the input register and is decoded there once the queue
// has room; its words then go into the result queue, which the output reads.
// A zero byte inside an open sequence yields two words, which the four-entry
// queue absorbs; the output drains one word per cycle while out_stall is low.
// Reset (arst_n, asynchronous, active low) empties the queue and the sequence state.
// An output stall holds the queue; with over two words in it, in_stall rises.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [7:0]                             in_byte,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [utf8sd_pkg::CpWidth-1:0]  code_point,
	output logic                                   is_last
);
	import utf8sd_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Sequence state.
	logic [1:0]          bytes_left_q;
	logic [AccWidth-1:0] accum_q;
	logic                bad_seq_q;

	// Result queue.
	result_t             fifo_q [FifoDepth];
	logic [PtrWidth-1:0] wr_ptr_q;
	logic [PtrWidth-1:0] rd_ptr_q;
	logic [CntWidth-1:0] cnt_q;

	// Decode outputs.
	logic [1:0]          bytes_left_d;
	logic [AccWidth-1:0] accum_d;
	logic                bad_seq_d;
	logic [1:0]          n_res;
	result_t             res0;
	result_t             res1;
	logic [AccWidth-1:0] cont_bits;
	logic [AccWidth-1:0] accum_new;

	logic proc;
	logic pop;

	// The byte in the register is decoded only when the queue can take two words,
	// which covers the worst case of a zero byte breaking a sequence.
	assign proc     = valid_s1 && (cnt_q <= CntWidth'(FifoDepth - 2));
	assign in_stall = valid_s1 && !proc;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// Continuation payload placed at the position that the remaining count sets.
	always_comb begin
		case (bytes_left_q)
			2'd3:    cont_bits = AccWidth'({byte_s1[5:0], 12'b0});
			2'd2:    cont_bits = AccWidth'({byte_s1[5:0], 6'b0});
			default: cont_bits = AccWidth'(byte_s1[5:0]);
		endcase
	end

	assign accum_new = accum_q | cont_bits;

	always_comb begin
		bytes_left_d = bytes_left_q;
		accum_d      = accum_q;
		bad_seq_d    = bad_seq_q;
		n_res        = 2'd0;
		res0         = '{code_point: CP_ERROR, is_last: 1'b1};
		res1         = '{code_point: '0, is_last: 1'b1};
		if (bytes_left_q == 2'd0) begin
			// No sequence open: classify the lead byte.
			if (!byte_s1[7]) begin
				n_res = 2'd1;
				res0  = '{code_point: CpWidth'(byte_s1[6:0]), is_last: 1'b1};
			end else if ((byte_s1 & LEAD2_MASK) == LEAD2_VAL) begin
				accum_d      = AccWidth'({byte_s1[4:0], 6'b0});
				bytes_left_d = 2'd1;
				bad_seq_d    = 1'b0;
			end else if ((byte_s1 & LEAD3_MASK) == LEAD3_VAL) begin
				accum_d      = AccWidth'({byte_s1[3:0], 12'b0});
				bytes_left_d = 2'd2;
				bad_seq_d    = 1'b0;
			end else if ((byte_s1 & LEAD4_MASK) == LEAD4_VAL) begin
				accum_d      = AccWidth'({byte_s1[2:0], 18'b0});
				bytes_left_d = 2'd3;
				bad_seq_d    = 1'b0;
			end else begin
				n_res = 2'd1;
			end
		end else if (byte_s1 == 8'd0) begin
			// A zero byte aborts the sequence and then stands as a character itself.
			bytes_left_d = 2'd0;
			accum_d      = '0;
			bad_seq_d    = 1'b0;
			n_res        = 2'd2;
			res0         = '{code_point: CP_ERROR, is_last: 1'b0};
		end else begin
			// Any other byte is consumed as a continuation, flagged if malformed.
			if (bytes_left_q == 2'd1) begin
				n_res = 2'd1;
				if (bad_seq_q || ((byte_s1 & CONT_MASK) != CONT_VAL)) begin
					res0 = '{code_point: CP_ERROR, is_last: 1'b1};
				end else begin
					res0 = '{code_point: CpWidth'(accum_new), is_last: 1'b1};
				end
				bytes_left_d = 2'd0;
				accum_d      = '0;
				bad_seq_d    = 1'b0;
			end else begin
				bytes_left_d = bytes_left_q - 2'd1;
				accum_d      = accum_new;
				bad_seq_d    = bad_seq_q || ((byte_s1 & CONT_MASK) != CONT_VAL);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			accum_q      <= '0;
			bad_seq_q    <= 1'b0;
		end else if (proc) begin
			bytes_left_q <= bytes_left_d;
			accum_q      <= accum_d;
			bad_seq_q    <= bad_seq_d;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + PtrWidth'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
			end
			cnt_q <= cnt_q + (proc ? CntWidth'(n_res) : '0) - CntWidth'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (n_res != 2'd0)) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (proc && (n_res == 2'd2)) begin
			fifo_q[wr_ptr_q + PtrWidth'(1)] <= res1;
		end
	end

	assign out_valid  = (cnt_q != '0);
	assign code_point = fifo_q[rd_ptr_q].code_point;
	assign is_last    = fifo_q[rd_ptr_q].is_last;

	// The queue never holds more words than it has entries.
	`UTF8SD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntWidth'(FifoDepth))
	// A malformed-sequence mark only exists while a sequence is open.
	`UTF8SD_ASSERT_NOW(a_bad_open, bad_seq_q, bytes_left_q != 2'd0)
	// Two words from one byte raise the fill count by two, less any word taken.
	`UTF8SD_ASSERT_NEXT(a_two_words, proc && (n_res == 2'd2),
		cnt_q == $past(cnt_q) + CntWidth'(2) - CntWidth'($past(pop)))
	// A byte held in the register is never dropped: it is decoded or it stalls input.
	`UTF8SD_ASSERT_NOW(a_hold, valid_s1 && !proc, in_stall)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for utf8_stream_decoder: byte stimulus, a code point predictor and
// a scoreboard that compares every output word in order.
// Depends on utf8sd_pkg and on the RTL of utf8_stream_decoder.
module tb_top;
	import utf8sd_pkg::*;

	// Number of random bytes after the directed opening, and the watchdog limit in cycles.
	localparam int RandomBytes = 550;
	localparam int CycleLimit  = 200000;
	localparam int TailCycles  = 8;

	// The predictor keeps its own copy of the sequence state and a queue of the words that
	// the decoder still owes. One method notes an accepted byte, another checks a word.
	class codepoint_tracker;
		logic [1:0]          cont_left = '0;
		logic [AccWidth-1:0] acc       = '0;
		bit                  seq_bad   = 1'b0;
		result_t             due[$];
		int                  words_checked = 0;
		int                  error_words   = 0;
		int                  faults        = 0;

		function void clear_seq();
			cont_left = '0;
			acc       = '0;
			seq_bad   = 1'b0;
		endfunction

		function void push_word(logic signed [CpWidth-1:0] cp, logic last);
			result_t w;
			w.code_point = cp;
			w.is_last    = last;
			due.push_back(w);
		endfunction

		function void take_byte(logic [7:0] b);
			int shamt;
			if (cont_left == 0) begin
				if (!b[7]) begin
					push_word(CpWidth'(b[6:0]), 1'b1);
				end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
					acc       = AccWidth'(b[4:0]) << 6;
					cont_left = 2'd1;
					seq_bad   = 1'b0;
				end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
					acc       = AccWidth'(b[3:0]) << 12;
					cont_left = 2'd2;
					seq_bad   = 1'b0;
				end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
					acc       = AccWidth'(b[2:0]) << 18;
					cont_left = 2'd3;
					seq_bad   = 1'b0;
				end else begin
					push_word(CP_ERROR, 1'b1);
				end
			end else if (b == 8'h00) begin
				// A zero cuts the open sequence short and then stands as a character itself.
				clear_seq();
				push_word(CP_ERROR, 1'b0);
				push_word('0, 1'b1);
			end else begin
				if ((b & CONT_MASK) != CONT_VAL)
					seq_bad = 1'b1;
				shamt     = 6 * (int'(cont_left) - 1);
				acc       = acc | (AccWidth'(b[5:0]) << shamt);
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					push_word(seq_bad ? CP_ERROR : {1'b0, acc}, 1'b1);
					clear_seq();
				end
			end
		endfunction

		function void check_word(logic signed [CpWidth-1:0] cp, logic last);
			result_t want;
			if (due.size() == 0) begin
				$error("unexpected word: code_point %0d, is_last %0b", cp, last);
				faults++;
				return;
			end
			want = due.pop_front();
			words_checked++;
			if (want.code_point == CP_ERROR)
				error_words++;
			if (cp !== want.code_point) begin
				$error("code_point: expected %0d, got %0d", want.code_point, cp);
				faults++;
			end
			if (last !== want.is_last) begin
				$error("is_last: expected %0b, got %0b", want.is_last, last);
				faults++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic [7:0]                 in_byte   = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [CpWidth-1:0]  code_point;
	logic                       is_last;

	codepoint_tracker tracker = new;

	// While calm is set neither side idles, so the block runs at its full rate for a while.
	bit calm        = 1'b0;
	bit paused_once = 1'b0;
	int bytes_sent  = 0;
	int calm_bytes  = 0;
	int cycles      = 0;

	// The opening bytes: the extremes of the byte range, invalid leads, a sequence of each
	// length with the largest four-byte one, a bad continuation, a new lead arriving inside a
	// sequence, and a zero byte that cuts a sequence short.
	logic [7:0] opening[$] = '{
		8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
		8'hC2, 8'hA9,
		8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h9F, 8'h98, 8'h80,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hC3, 8'h41,
		8'hE2, 8'hC3, 8'h80,
		8'hF4, 8'h80, 8'h80, 8'h00
	};

	utf8_stream_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.is_last    (is_last)
	);

	always #5 clk = ~clk;

	// The receiving side: the stall changes on the falling edge, and a word is taken at a
	// rising edge where it is offered and not stalled.
	always @(negedge clk) begin
		out_stall = !calm && arst_n && ($urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_word(code_point, is_last);
	end

	// Watchdog: a hung handshake must not leave the run open for ever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("utf8_stream_decoder: mismatch");
			$finish;
		end
	end

	// Offers one byte from the falling edge on, with random idle cycles before it, and
	// holds it until the decoder takes it. Called and returning at a falling edge.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte  = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_byte(b);
		bytes_sent++;
		if (calm)
			calm_bytes++;
		@(negedge clk);
	endtask

	// Stops the byte stream until every word owed has come out, then lets the pipeline settle.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (TailCycles) @(negedge clk);
	endtask

	// One character of the random part. Most are well formed with random payload bits; a
	// quarter of the longer ones are spoilt by a zero or by a byte that is not a
	// continuation, and a tenth of the time a raw random byte is sent instead.
	task automatic send_char();
		int         kind;
		int         len;
		int         spoil;
		logic [7:0] lead;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 10) begin
			send_byte(8'($urandom_range(255)));
			return;
		end
		len = $urandom_range(1, 4);
		case (len)
			1: begin
				lead = 8'($urandom_range(127));
			end
			2: begin
				lead = LEAD2_VAL | 8'($urandom_range(31));
			end
			3: begin
				lead = LEAD3_VAL | 8'($urandom_range(15));
			end
			default: begin
				lead = LEAD4_VAL | 8'($urandom_range(7));
			end
		endcase
		spoil = (kind >= 75 && len > 1) ? $urandom_range(1, len - 1) : 0;
		send_byte(lead);
		for (int i = 1; i < len; i++) begin
			if (i == spoil) begin
				if ($urandom_range(1) == 1) begin
					// The zero closes the sequence, so nothing more belongs to it.
					send_byte(8'h00);
					return;
				end
				do
					b = 8'($urandom_range(1, 255));
				while ((b & CONT_MASK) == CONT_VAL);
				send_byte(b);
			end else begin
				send_byte(CONT_VAL | 8'($urandom_range(63)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i])
			send_byte(opening[i]);
		wait_drained();

		while (bytes_sent < opening.size() + RandomBytes) begin
			// A stretch in the middle runs without any idling on either side.
			calm = (bytes_sent >= 150 && bytes_sent < 290);
			if (!paused_once && bytes_sent >= 380) begin
				paused_once = 1'b1;
				wait_drained();
			end
			send_char();
		end
		calm = 1'b0;
		wait_drained();

		$display("Sent %0d bytes (%0d with both sides at full rate), checked %0d words.",
			bytes_sent, calm_bytes, tracker.words_checked);
		$display("Of those words %0d reported a malformed sequence; %0d faults were found.",
			tracker.error_words, tracker.faults);
		if (tracker.faults == 0) begin
			$display("utf8_stream_decoder: match");
		end else begin
			$display("utf8_stream_decoder: mismatch");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8_stream_decoder.sv
tb/tb_top.sv
